// File: src/csrel_pkg.sv
`default_nettype none

package csrel_pkg;

   // default sizes of the stores
   localparam int unsigned MAX_ROWS_DEF    = 1024;
   localparam int unsigned MAX_ENTRIES_DEF = 4096;
   localparam int unsigned VALUE_BITS_DEF  = 64;

   // field widths
   localparam int unsigned KIND_W     = 2;
   localparam int unsigned POS_W      = 12;
   localparam int unsigned PTR_W      = 13;
   localparam int unsigned ROW_W      = 10;
   localparam int unsigned COL_W      = 10;
   localparam int unsigned PAYLOAD_W  = 64;
   localparam int unsigned STATUS_W   = 2;
   localparam int unsigned ROWCNT_W   = 11;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_LOAD_PTR   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LOAD_ENTRY = 2'd1;
   localparam logic [KIND_W-1:0] KIND_QUERY      = 2'd2;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_FOUND     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ROW_RANGE = 2'd2;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [PAYLOAD_W-1:0] element;
      logic [POS_W-1:0]     entry_position;
   } rslt_type;

endpackage

`default_nettype wire

// File: src/csr_element_lookup_core.sv
`default_nettype none

// Element lookup in a sparse matrix held in compressed-row form. Load transfers
// (kind 0: row begin pointer, kind 1: column index plus value) write the row
// table or the entry store in the cycle they are taken and give no response;
// a load position beyond a store is dropped. A query transfer (kind 2) names
// a row and a column and yields exactly one response: status found with the
// value and its entry index, not found with zeros, or row out of range when
// the row is at or beyond csr row_count (capped at MAX_ROWS). Kind 3 is
// dropped. Entries must be written before a query reaches them.
// Steps: a load or an out-of-range query is handled in the cycle it is taken.
// An in-range query reads the begin and then the end row pointer, then makes
// binary-search probes (at most ceil(log2(n+1)) for a row of n entries, 13 for
// 4096 entries), each a read of the entry store, which has one read port.
// Only one query is in flight; req_stall is high while it runs. A finished
// response sits in the output register, so the next transfer is taken while
// it waits; the engine holds a further response until that register frees up.
// row_count is written through the csr channel, which is always ready; write
// it only while no query is in flight.
module csr_element_lookup_core #(
   parameter int unsigned MAX_ROWS    = csrel_pkg::MAX_ROWS_DEF,
   parameter int unsigned MAX_ENTRIES = csrel_pkg::MAX_ENTRIES_DEF,
   parameter int unsigned VALUE_BITS  = csrel_pkg::VALUE_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [csrel_pkg::KIND_W-1:0]      req_kind,
   input  wire logic [csrel_pkg::POS_W-1:0]       req_position,
   input  wire logic [csrel_pkg::PTR_W-1:0]       req_offset,
   input  wire logic [csrel_pkg::ROW_W-1:0]       req_row,
   input  wire logic [csrel_pkg::COL_W-1:0]       req_column,
   input  wire logic [csrel_pkg::PAYLOAD_W-1:0]   req_payload,
   // response channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic      [csrel_pkg::STATUS_W-1:0]    rsp_status,
   output logic      [csrel_pkg::PAYLOAD_W-1:0]   rsp_element,
   output logic      [csrel_pkg::POS_W-1:0]       rsp_entry_position,
   // row_count register write
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [csrel_pkg::ROWCNT_W-1:0]    csr_data
);

   logic                           req_accept;
   logic                           out_free;
   logic                           eng_busy;
   logic                           eng_rslt_valid;
   csrel_pkg::rslt_type            eng_rslt;

   logic [csrel_pkg::ROWCNT_W-1:0] row_count_ff, row_count_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   csrel_pkg::rslt_type            rsp_data_ff, rsp_data_in;

   // one transfer at a time while the engine walks a row
   assign req_stall  = eng_busy;
   assign req_accept = req_valid && !req_stall;

   // output slot is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign csr_ready    = 1'b1;
   assign row_count_in = (csr_valid && csr_ready) ? csr_data : row_count_ff;

   csrel_engine #(
      .MAX_ROWS    (MAX_ROWS),
      .MAX_ENTRIES (MAX_ENTRIES),
      .VALUE_BITS  (VALUE_BITS)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .req_accept   (req_accept),
      .req_kind     (req_kind),
      .req_position (req_position),
      .req_offset   (req_offset),
      .req_row      (req_row),
      .req_column   (req_column),
      .req_payload  (req_payload),
      .row_count    (row_count_ff),
      .out_free     (out_free),
      .busy         (eng_busy),
      .rslt_valid   (eng_rslt_valid),
      .rslt         (eng_rslt)
   );

   // output register: load on free slot, otherwise hold
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free) begin
         rsp_valid_in = eng_rslt_valid;
         if (eng_rslt_valid) begin
            rsp_data_in = eng_rslt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_count_ff <= row_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_data_ff.status;
   assign rsp_element        = rsp_data_ff.element;
   assign rsp_entry_position = rsp_data_ff.entry_position;

   // a query either keeps the engine busy or has its response registered
   a_query_progress: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_kind == csrel_pkg::KIND_QUERY)) |=> (req_stall || rsp_valid))
      else $error("query neither in flight nor answered");

   // a response handed to a free output slot shows up next cycle
   a_rslt_taken: assert property (@(posedge clock) disable iff (reset)
      (eng_rslt_valid && out_free) |=> rsp_valid)
      else $error("engine response lost");

   // element and index are zero unless the entry was found
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != csrel_pkg::STATUS_FOUND)) |->
         ((rsp_element == '0) && (rsp_entry_position == '0)))
      else $error("nonzero payload on miss");

endmodule

`default_nettype wire

// File: src/csrel_ram.sv
`default_nettype none

// simple dual-port RAM, one write and one registered read per cycle
module csrel_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: src/csrel_engine.sv
`default_nettype none

// Load decode, pointer fetch and binary-search sequencer around the two stores.
module csrel_engine #(
   parameter int unsigned MAX_ROWS    = csrel_pkg::MAX_ROWS_DEF,
   parameter int unsigned MAX_ENTRIES = csrel_pkg::MAX_ENTRIES_DEF,
   parameter int unsigned VALUE_BITS  = csrel_pkg::VALUE_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_accept,
   input  wire logic [csrel_pkg::KIND_W-1:0]       req_kind,
   input  wire logic [csrel_pkg::POS_W-1:0]        req_position,
   input  wire logic [csrel_pkg::PTR_W-1:0]        req_offset,
   input  wire logic [csrel_pkg::ROW_W-1:0]        req_row,
   input  wire logic [csrel_pkg::COL_W-1:0]        req_column,
   input  wire logic [csrel_pkg::PAYLOAD_W-1:0]    req_payload,
   input  wire logic [csrel_pkg::ROWCNT_W-1:0]     row_count,
   input  wire logic                               out_free,
   output logic                                    busy,
   output logic                                    rslt_valid,
   output csrel_pkg::rslt_type                     rslt
);

   localparam int unsigned RAW = $clog2(MAX_ROWS + 1);
   localparam int unsigned EAW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int unsigned LW  = $clog2(MAX_ENTRIES + 1);
   localparam int unsigned EW  = csrel_pkg::COL_W + VALUE_BITS;

   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_FETCH_LO = 5'b00010,
      ST_FETCH_HI = 5'b00100,
      ST_PROBE    = 5'b01000,
      ST_WAIT     = 5'b10000
   } eng_state_type;

   function automatic logic [LW-1:0] clamp_ptr(input logic [csrel_pkg::PTR_W-1:0] p);
      logic [31:0] p32;
      p32 = 32'(p);
      if (p32 > MAX_ENTRIES) begin
         p32 = MAX_ENTRIES;
      end
      return p32[LW-1:0];
   endfunction

   eng_state_type state_ff, state_in;
   logic [csrel_pkg::COL_W-1:0] col_ff, col_in;
   logic [RAW-1:0]              rnext_ff, rnext_in;
   logic [LW-1:0]               lo_ff, lo_in;
   logic [LW-1:0]               hi_ff, hi_in;
   logic [LW-1:0]               mid_ff, mid_in;
   csrel_pkg::rslt_type         pend_ff, pend_in;

   // store ports
   logic                        rt_we;
   logic [RAW-1:0]              rt_waddr, rt_raddr;
   logic [csrel_pkg::PTR_W-1:0] rt_rdata;
   logic                        en_we;
   logic [EAW-1:0]              en_waddr, en_raddr;
   logic [EW-1:0]               en_wdata, en_rdata;

   logic [31:0] pos32, row32, rn32, limit32, nmid32, mid32;
   logic        row_oor;

   logic [LW-1:0] ptr_clamped, fh_mid, nlo, nhi, nmid, issue_mid;
   logic [csrel_pkg::COL_W-1:0] e_col;
   logic [VALUE_BITS-1:0]       e_val;
   logic        hit, go_right;

   logic                done;
   csrel_pkg::rslt_type res_now;

   // load decode
   assign pos32   = 32'(req_position);
   assign row32   = 32'(req_row);
   assign rn32    = row32 + 32'd1;
   assign limit32 = (32'(row_count) > MAX_ROWS) ? MAX_ROWS : 32'(row_count);
   assign row_oor = row32 >= limit32;

   assign rt_we    = req_accept && (req_kind == csrel_pkg::KIND_LOAD_PTR) &&
                     (pos32 < (MAX_ROWS + 1));
   assign rt_waddr = pos32[RAW-1:0];
   assign en_we    = req_accept && (req_kind == csrel_pkg::KIND_LOAD_ENTRY) &&
                     (pos32 < MAX_ENTRIES);
   assign en_waddr = pos32[EAW-1:0];
   assign en_wdata = {req_column, req_payload[VALUE_BITS-1:0]};

   // row table: begin pointer read at accept, end pointer in the next cycle (ST_FETCH_LO)
   assign rt_raddr = (state_ff == ST_FETCH_LO) ? rnext_ff : row32[RAW-1:0];

   // probe datapath
   assign ptr_clamped = clamp_ptr(rt_rdata);
   assign fh_mid      = lo_ff + ((ptr_clamped - lo_ff) >> 1);
   assign e_col       = en_rdata[EW-1:VALUE_BITS];
   assign e_val       = en_rdata[VALUE_BITS-1:0];
   assign hit         = (e_col == col_ff);
   assign go_right    = (e_col < col_ff);
   assign nlo         = go_right ? (mid_ff + LW'(1)) : lo_ff;
   assign nhi         = go_right ? hi_ff : mid_ff;
   assign nmid        = nlo + ((nhi - nlo) >> 1);
   assign issue_mid   = (state_ff == ST_FETCH_HI) ? fh_mid : nmid;
   assign nmid32      = 32'(issue_mid);
   assign en_raddr    = nmid32[EAW-1:0];
   assign mid32       = 32'(mid_ff);

   csrel_ram #(
      .WIDTH (csrel_pkg::PTR_W),
      .DEPTH (MAX_ROWS + 1)
   ) u_row_table (
      .clock   (clock),
      .wr_en   (rt_we),
      .wr_addr (rt_waddr),
      .wr_data (req_offset),
      .rd_addr (rt_raddr),
      .rd_data (rt_rdata)
   );

   // column index and value share one word per entry
   csrel_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_ENTRIES)
   ) u_entry_store (
      .clock   (clock),
      .wr_en   (en_we),
      .wr_addr (en_waddr),
      .wr_data (en_wdata),
      .rd_addr (en_raddr),
      .rd_data (en_rdata)
   );

   always_comb begin
      state_in   = state_ff;
      col_in     = col_ff;
      rnext_in   = rnext_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      mid_in     = mid_ff;
      pend_in    = pend_ff;
      rslt_valid = 1'b0;
      rslt       = pend_ff;
      done       = 1'b0;
      res_now    = '{status: csrel_pkg::STATUS_NOT_FOUND, element: '0, entry_position: '0};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_kind == csrel_pkg::KIND_QUERY)) begin
               col_in   = req_column;
               rnext_in = rn32[RAW-1:0];
               if (row_oor) begin
                  done           = 1'b1;
                  res_now.status = csrel_pkg::STATUS_ROW_RANGE;
               end else begin
                  state_in = ST_FETCH_LO;
               end
            end
         end
         ST_FETCH_LO: begin
            lo_in    = ptr_clamped;
            state_in = ST_FETCH_HI;
         end
         ST_FETCH_HI: begin
            if (lo_ff < ptr_clamped) begin
               hi_in    = ptr_clamped;
               mid_in   = fh_mid;
               state_in = ST_PROBE;
            end else begin
               done = 1'b1;
            end
         end
         ST_PROBE: begin
            if (hit) begin
               done                   = 1'b1;
               res_now.status         = csrel_pkg::STATUS_FOUND;
               res_now.element        = csrel_pkg::PAYLOAD_W'(e_val);
               res_now.entry_position = mid32[csrel_pkg::POS_W-1:0];
            end else if (nlo < nhi) begin
               lo_in  = nlo;
               hi_in  = nhi;
               mid_in = nmid;
            end else begin
               done = 1'b1;
            end
         end
         ST_WAIT: begin
            rslt_valid = 1'b1;
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (done) begin
         rslt_valid = 1'b1;
         rslt       = res_now;
         if (out_free) begin
            state_in = ST_IDLE;
         end else begin
            pend_in  = res_now;
            state_in = ST_WAIT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      col_ff   <= col_in;
      rnext_ff <= rnext_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      mid_ff   <= mid_in;
      pend_ff  <= pend_in;
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

// File: tb/tb_csr_element_lookup_core.sv
`timescale 1ns / 1ps

module tb_csr_element_lookup_core;

   localparam int unsigned MAX_ROWS    = csrel_pkg::MAX_ROWS_DEF;
   localparam int unsigned MAX_ENTRIES = csrel_pkg::MAX_ENTRIES_DEF;
   localparam logic [csrel_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;   // block drops it
   localparam int unsigned TARGET_ITEMS = 760;          // scripted + random
   localparam int unsigned LONG_HOLD    = 400;          // cycles of rsp_stall
   localparam int unsigned SETTLE       = 20;           // > longest query

   localparam logic [csrel_pkg::PAYLOAD_W-1:0] PAY_ONES = {csrel_pkg::PAYLOAD_W{1'b1}};
   localparam logic [csrel_pkg::PAYLOAD_W-1:0] PAY_FIVE = 64'h5555_5555_5555_5555;
   localparam logic [csrel_pkg::PAYLOAD_W-1:0] PAY_TEN  = 64'hAAAA_AAAA_AAAA_AAAA;
   localparam logic [csrel_pkg::PAYLOAD_W-1:0] PAY_ENDS = 64'h8000_0000_0000_0001;
   localparam logic [csrel_pkg::PAYLOAD_W-1:0] PAY_MIX  = 64'h0123_4567_89AB_CDEF;

   localparam csrel_pkg::rslt_type NO_RSLT    = '0;
   localparam csrel_pkg::rslt_type RANGE_ZERO = {csrel_pkg::STATUS_ROW_RANGE, 64'd0, 12'd0};
   localparam csrel_pkg::rslt_type MISS_ZERO  = {csrel_pkg::STATUS_NOT_FOUND, 64'd0, 12'd0};
   localparam csrel_pkg::rslt_type LAST_HIT   = {csrel_pkg::STATUS_FOUND, PAY_MIX, 12'd4095};

   typedef struct packed {
      logic [csrel_pkg::KIND_W-1:0]    kind;
      logic [csrel_pkg::POS_W-1:0]     position;
      logic [csrel_pkg::PTR_W-1:0]     offset;
      logic [csrel_pkg::ROW_W-1:0]     row;
      logic [csrel_pkg::COL_W-1:0]     column;
      logic [csrel_pkg::PAYLOAD_W-1:0] payload;
   } req_item_type;

   // one line of the scripted sequence; golden rows carry a hand-written answer
   typedef struct packed {
      logic                           csr_write;
      logic [csrel_pkg::ROWCNT_W-1:0] csr_value;
      logic                           golden;
      csrel_pkg::rslt_type            want;
      req_item_type                   item;
   } script_row_type;

   // ---------------------------------------------------------------------------
   // DUT ports; every input has a known value from time zero
   // ---------------------------------------------------------------------------
   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [csrel_pkg::KIND_W-1:0]    req_kind = '0;
   logic [csrel_pkg::POS_W-1:0]     req_position = '0;
   logic [csrel_pkg::PTR_W-1:0]     req_offset = '0;
   logic [csrel_pkg::ROW_W-1:0]     req_row = '0;
   logic [csrel_pkg::COL_W-1:0]     req_column = '0;
   logic [csrel_pkg::PAYLOAD_W-1:0] req_payload = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [csrel_pkg::STATUS_W-1:0]  rsp_status;
   logic [csrel_pkg::PAYLOAD_W-1:0] rsp_element;
   logic [csrel_pkg::POS_W-1:0]     rsp_entry_position;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [csrel_pkg::ROWCNT_W-1:0]  csr_data = '0;

   csr_element_lookup_core u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_position       (req_position),
      .req_offset         (req_offset),
      .req_row            (req_row),
      .req_column         (req_column),
      .req_payload        (req_payload),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_element        (rsp_element),
      .rsp_entry_position (rsp_entry_position),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_data           (csr_data)
   );

   // ---------------------------------------------------------------------------
   // Shadow copy of the matrix stores. The *_set flags track which slots have
   // been loaded so that no query is ever sent that would read a blank slot.
   // ---------------------------------------------------------------------------
   logic [csrel_pkg::PTR_W-1:0]     row_begin     [0:MAX_ROWS];
   bit                              row_begin_set [0:MAX_ROWS];
   logic [csrel_pkg::COL_W-1:0]     entry_col     [0:MAX_ENTRIES-1];
   logic [csrel_pkg::PAYLOAD_W-1:0] entry_val     [0:MAX_ENTRIES-1];
   bit                              entry_set     [0:MAX_ENTRIES-1];
   int unsigned                     rows_in_use = 0;

   csrel_pkg::rslt_type pending_rslt[$];   // lookups owed by the block, oldest first

   int sender_idle_pct = 0;
   int rsp_stall_pct   = 0;
   bit hold_armed      = 1'b0;
   logic long_hold     = 1'b0;

   int mismatches   = 0;
   int useful_items = 0;
   int n_loads      = 0;
   int n_ignored    = 0;
   int n_found      = 0;
   int n_missing    = 0;
   int n_range      = 0;
   int n_settings   = 0;

   initial begin : clock_gen
      forever #2 clock = ~clock;
   end

   // Hard stop, far beyond the slowest legal run.
   initial begin : watchdog
      #4_000_000;
      $display("csr_element_lookup_core: mismatch");
      $finish;
   end

   // Receiver: random stall, plus one long hold that backs the block up.
   always @(posedge clock) begin
      rsp_stall <= long_hold || ($urandom_range(0, 99) < rsp_stall_pct);
   end

   // The long hold counts its own cycles so the sender keeps pushing meanwhile.
   initial begin : long_hold_proc
      wait (hold_armed);
      @(posedge clock);
      long_hold <= 1'b1;
      repeat (LONG_HOLD) @(posedge clock);
      long_hold <= 1'b0;
   end

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatches++;
      $display("ERROR @%0t: %s got %h, want %h", $time, field, got, want);
   endtask

   function automatic int unsigned cap_entry(input logic [csrel_pkg::PTR_W-1:0] p);
      return (p > MAX_ENTRIES) ? MAX_ENTRIES : p;
   endfunction

   // Binary search of one row, same probe order as the hardware. Returns 1 when
   // the search would read a row pointer or a slot that was never loaded.
   function automatic bit lookup_element(input logic [csrel_pkg::ROW_W-1:0] row,
                                         input logic [csrel_pkg::COL_W-1:0] col,
                                         output csrel_pkg::rslt_type res);
      int unsigned ceiling;
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      res = MISS_ZERO;
      ceiling = (rows_in_use > MAX_ROWS) ? MAX_ROWS : rows_in_use;
      if (row >= ceiling) begin
         res.status = csrel_pkg::STATUS_ROW_RANGE;
         return 1'b0;
      end
      if (!row_begin_set[row] || !row_begin_set[row + 1])
         return 1'b1;
      lo = cap_entry(row_begin[row]);
      hi = cap_entry(row_begin[row + 1]);   // end below begin: empty row
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (!entry_set[mid])
            return 1'b1;
         if (entry_col[mid] == col) begin
            res.status         = csrel_pkg::STATUS_FOUND;
            res.element        = entry_val[mid];
            res.entry_position = csrel_pkg::POS_W'(mid);
            return 1'b0;
         end
         if (entry_col[mid] < col)
            lo = mid + 1;
         else
            hi = mid;
      end
      return 1'b0;
   endfunction

   function automatic req_item_type mk_item(input logic [csrel_pkg::KIND_W-1:0] kind,
                                            input logic [csrel_pkg::POS_W-1:0] position,
                                            input logic [csrel_pkg::PTR_W-1:0] offset,
                                            input logic [csrel_pkg::ROW_W-1:0] row,
                                            input logic [csrel_pkg::COL_W-1:0] column,
                                            input logic [csrel_pkg::PAYLOAD_W-1:0] payload);
      return {kind, position, offset, row, column, payload};
   endfunction

   function automatic script_row_type script(input int csr_pre, input bit golden,
                                             input csrel_pkg::rslt_type want,
                                             input req_item_type it);
      script_row_type s;
      s.csr_write = (csr_pre >= 0);
      s.csr_value = csrel_pkg::ROWCNT_W'(csr_pre);
      s.golden    = golden;
      s.want      = want;
      s.item      = it;
      return s;
   endfunction

   // Junk the block must swallow: kind 3, or a row pointer past the table.
   function automatic req_item_type noise_item();
      if ($urandom_range(0, 1))
         return mk_item(KIND_UNUSED, $urandom, $urandom, $urandom, $urandom,
                        {$urandom, $urandom});
      return mk_item(csrel_pkg::KIND_LOAD_PTR, $urandom_range(MAX_ROWS + 1, 4095),
                     $urandom, $urandom, $urandom, {$urandom, $urandom});
   endfunction

   // Applies one accepted request transfer to the shadow stores.
   function automatic void absorb_item(input req_item_type it, input bit golden,
                                       input csrel_pkg::rslt_type want);
      csrel_pkg::rslt_type predicted;
      case (it.kind)
         csrel_pkg::KIND_LOAD_PTR: begin
            if (it.position <= MAX_ROWS) begin
               row_begin[it.position]     = it.offset;
               row_begin_set[it.position] = 1'b1;
               n_loads++;
               useful_items++;
            end else begin
               n_ignored++;
            end
         end
         csrel_pkg::KIND_LOAD_ENTRY: begin
            if (it.position < MAX_ENTRIES) begin
               entry_col[it.position] = it.column;
               entry_val[it.position] = it.payload;
               entry_set[it.position] = 1'b1;
               n_loads++;
               useful_items++;
            end else begin
               n_ignored++;
            end
         end
         csrel_pkg::KIND_QUERY: begin
            void'(lookup_element(it.row, it.column, predicted));
            if (golden)
               predicted = want;
            pending_rslt.push_back(predicted);
            useful_items++;
            case (predicted.status)
               csrel_pkg::STATUS_FOUND:     n_found++;
               csrel_pkg::STATUS_NOT_FOUND: n_missing++;
               default:                     n_range++;
            endcase
         end
         default: n_ignored++;
      endcase
   endfunction

   // Sender: optional idle cycles, then hold the transfer until it is taken.
   task automatic offer_item(input req_item_type it, input bit golden,
                             input csrel_pkg::rslt_type want);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_kind     <= it.kind;
      req_position <= it.position;
      req_offset   <= it.offset;
      req_row      <= it.row;
      req_column   <= it.column;
      req_payload  <= it.payload;
      do @(posedge clock); while (req_stall);
      absorb_item(it, golden, want);
   endtask

   // row_count is only touched with the block idle: all responses back, then a
   // settling wait (SETTLE) for any load still in its write cycle.
   task automatic write_row_count(input logic [csrel_pkg::ROWCNT_W-1:0] value);
      req_valid <= 1'b0;
      while (pending_rslt.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      rows_in_use = value;
      n_settings++;
   endtask

   // One random phase: program row_count, load a small matrix, query it.
   task automatic run_phase(input int phase, input logic [csrel_pkg::ROWCNT_W-1:0] rc);
      int unsigned limit;
      int unsigned nr;
      int unsigned first;
      int unsigned total;
      int unsigned base;
      int unsigned prefix;
      int unsigned c;
      int unsigned pick;
      int unsigned cnt [0:11];
      int unsigned nq;
      logic [csrel_pkg::PTR_W-1:0] off;
      logic [csrel_pkg::COL_W-1:0] col;
      logic [19:0] hit_pairs[$];
      req_item_type it;
      csrel_pkg::rslt_type scratch;
      bit scramble;

      case (phase % 4)
         0: begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
         1: begin sender_idle_pct = 54; rsp_stall_pct = 0;  end
         2: begin sender_idle_pct = 0;  rsp_stall_pct = 54; end
         default: begin sender_idle_pct = 25; rsp_stall_pct = 25; end
      endcase
      write_row_count(rc);

      limit = (rc > MAX_ROWS) ? MAX_ROWS : rc;
      nr    = (limit == 0) ? 0 : $urandom_range(1, (limit < 12) ? limit : 12);
      first = (limit == 0) ? 0 : $urandom_range(0, limit - nr);
      total = 0;
      for (int i = 0; i < nr; i++) begin
         cnt[i] = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                              : $urandom_range(0, 10);
         total += cnt[i];
      end
      base = ($urandom_range(0, 4) == 0) ? MAX_ENTRIES - total
                                         : $urandom_range(0, MAX_ENTRIES - total);

      // row pointers first; an end pointer at the top may be any saturating value
      prefix = base;
      for (int i = 0; i <= nr && nr != 0; i++) begin
         off = prefix;
         if (prefix == MAX_ENTRIES && $urandom_range(0, 1))
            off = $urandom_range(MAX_ENTRIES, 8191);
         if ($urandom_range(0, 19) == 0)
            offer_item(noise_item(), 1'b0, NO_RSLT);
         offer_item(mk_item(csrel_pkg::KIND_LOAD_PTR, first + i, off, $urandom,
                            $urandom, {$urandom, $urandom}), 1'b0, NO_RSLT);
         if (i < nr)
            prefix += cnt[i];
      end

      // entries: columns ascending (duplicates can pile up at 1023), a few
      // rows deliberately unsorted
      prefix = base;
      for (int i = 0; i < nr; i++) begin
         scramble = ($urandom_range(0, 9) == 0);
         c = $urandom_range(0, 40);
         for (int k = 0; k < cnt[i]; k++) begin
            col = scramble ? csrel_pkg::COL_W'($urandom_range(0, 1023))
                           : csrel_pkg::COL_W'(c);
            c = c + $urandom_range(1, 30);
            if (c > 1023)
               c = 1023;
            if ($urandom_range(0, 19) == 0)
               offer_item(noise_item(), 1'b0, NO_RSLT);
            offer_item(mk_item(csrel_pkg::KIND_LOAD_ENTRY, prefix + k, $urandom,
                               $urandom, col, {$urandom, $urandom}), 1'b0, NO_RSLT);
            hit_pairs.push_back({csrel_pkg::ROW_W'(first + i), col});
         end
         prefix += cnt[i];
      end

      // back-pressure phase: responses held off while queries keep coming
      if (phase == 4)
         hold_armed = 1'b1;
      nq = (phase == 4) ? 60 : $urandom_range(25, 50);
      for (int q = 0; q < nq; q++) begin
         pick = $urandom_range(0, 99);
         if (pick >= 92) begin
            offer_item(noise_item(), 1'b0, NO_RSLT);
            continue;
         end
         it = mk_item(csrel_pkg::KIND_QUERY, $urandom, $urandom, $urandom, $urandom,
                      {$urandom, $urandom});
         if (nr != 0) begin
            if (pick < 55 && hit_pairs.size() != 0) begin
               {it.row, it.column} = hit_pairs[$urandom_range(0, hit_pairs.size() - 1)];
            end else if (pick < 75) begin
               it.row = first + $urandom_range(0, nr - 1);
            end else if (pick < 85) begin
               it.row    = first + $urandom_range(0, nr - 1);
               it.column = it.row;   // diagonal element
            end else if (limit < MAX_ROWS) begin
               it.row = $urandom_range(limit, MAX_ROWS - 1);
            end
         end
         // random rows may point at stale or blank slots; fall back to a fresh row
         if (lookup_element(it.row, it.column, scratch))
            it.row = first + $urandom_range(0, nr - 1);
         offer_item(it, 1'b0, NO_RSLT);
      end
   endtask

   // ---------------------------------------------------------------------------
   // Response checker: every transfer is matched against the oldest expectation.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : rsp_check
      csrel_pkg::rslt_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rslt.size() == 0) begin
            report_mismatch("unexpected response, status", rsp_status, 0);
         end else begin
            want = pending_rslt.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_element !== want.element)
               report_mismatch("element", rsp_element, want.element);
            if (rsp_entry_position !== want.entry_position)
               report_mismatch("entry_position", rsp_entry_position,
                               want.entry_position);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin : stimulus
      script_row_type directed_q[$];
      int phase;
      logic [csrel_pkg::ROWCNT_W-1:0] rc;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // row_count is still 0 from reset: everything is out of range
      directed_q.push_back(script(-1, 1, RANGE_ZERO,
         mk_item(csrel_pkg::KIND_QUERY, 0, 0, 0, 0, 0)));
      directed_q.push_back(script(-1, 1, RANGE_ZERO,
         mk_item(csrel_pkg::KIND_QUERY, 4095, 8191, 1023, 1023, PAY_ONES)));
      // row_count above the table acts as the full table; last row sits at the
      // top of the entry store, its end pointer saturating at the store size
      directed_q.push_back(script(2047, 0, NO_RSLT,
         mk_item(csrel_pkg::KIND_LOAD_PTR, 1023, 4090, 0, 0, 0)));
      directed_q.push_back(script(-1, 0, NO_RSLT,
         mk_item(csrel_pkg::KIND_LOAD_PTR, 1024, 8191, 0, 0, 0)));
      directed_q.push_back(script(-1, 0, NO_RSLT,
         mk_item(csrel_pkg::KIND_LOAD_ENTRY, 4090, 0, 0, 5, 0)));
      directed_q.push_back(script(-1, 0, NO_RSLT,
         mk_item(csrel_pkg::KIND_LOAD_ENTRY, 4091, 0, 0, 100, PAY_ONES)));
      directed_q.push_back(script(-1, 0, NO_RSLT,
         mk_item(csrel_pkg::KIND_LOAD_ENTRY, 4092, 0, 0, 300, PAY_FIVE)));
      directed_q.push_back(script(-1, 0, NO_RSLT,
         mk_item(csrel_pkg::KIND_LOAD_ENTRY, 4093, 0, 0, 600, PAY_TEN)));
      directed_q.push_back(script(-1, 0, NO_RSLT,
         mk_item(csrel_pkg::KIND_LOAD_ENTRY, 4094, 0, 0, 900, PAY_ENDS)));
      directed_q.push_back(script(-1, 0, NO_RSLT,
         mk_item(csrel_pkg::KIND_LOAD_ENTRY, 4095, 0, 0, 1023, PAY_MIX)));
      directed_q.push_back(script(-1, 1, LAST_HIT,
         mk_item(csrel_pkg::KIND_QUERY, 0, 0, 1023, 1023, 0)));
      directed_q.push_back(script(-1, 1, MISS_ZERO,
         mk_item(csrel_pkg::KIND_QUERY, 0, 0, 1023, 0, 0)));
      directed_q.push_back(script(-1, 0, NO_RSLT,
         mk_item(csrel_pkg::KIND_QUERY, 0, 0, 1023, 100, 0)));
      directed_q.push_back(script(-1, 0, NO_RSLT,
         mk_item(csrel_pkg::KIND_QUERY, 0, 0, 1023, 5, 0)));
      // dropped transfers: kind 3 and a pointer index past the table
      directed_q.push_back(script(-1, 0, NO_RSLT,
         mk_item(KIND_UNUSED, 4095, 8191, 1023, 1023, PAY_ONES)));
      directed_q.push_back(script(-1, 0, NO_RSLT,
         mk_item(csrel_pkg::KIND_LOAD_PTR, 4095, 8191, 0, 0, 0)));
      // row 0 with its end below its begin reads as empty
      directed_q.push_back(script(-1, 0, NO_RSLT,
         mk_item(csrel_pkg::KIND_LOAD_PTR, 0, 4092, 0, 0, 0)));
      directed_q.push_back(script(-1, 0, NO_RSLT,
         mk_item(csrel_pkg::KIND_LOAD_PTR, 1, 4090, 0, 0, 0)));
      directed_q.push_back(script(-1, 1, MISS_ZERO,
         mk_item(csrel_pkg::KIND_QUERY, 0, 0, 0, 300, 0)));
      directed_q.push_back(script(-1, 0, NO_RSLT,
         mk_item(csrel_pkg::KIND_LOAD_PTR, 1, 4095, 0, 0, 0)));
      directed_q.push_back(script(-1, 0, NO_RSLT,
         mk_item(csrel_pkg::KIND_QUERY, 0, 0, 0, 900, 0)));
      // single row in use
      directed_q.push_back(script(1, 0, NO_RSLT,
         mk_item(csrel_pkg::KIND_QUERY, 0, 0, 0, 600, 0)));
      directed_q.push_back(script(-1, 1, RANGE_ZERO,
         mk_item(csrel_pkg::KIND_QUERY, 0, 0, 1, 0, 0)));
      // exactly the full table
      directed_q.push_back(script(1024, 0, NO_RSLT,
         mk_item(csrel_pkg::KIND_QUERY, 0, 0, 1023, 900, 0)));

      foreach (directed_q[i]) begin
         if (directed_q[i].csr_write)
            write_row_count(directed_q[i].csr_value);
         offer_item(directed_q[i].item, directed_q[i].golden, directed_q[i].want);
      end

      // random phases cycle through row_count extremes and idle patterns
      phase = 0;
      while (useful_items < TARGET_ITEMS) begin
         case (phase % 7)
            0: rc = $urandom_range(1, 16);
            1: rc = MAX_ROWS;
            2: rc = 0;
            3: rc = $urandom_range(MAX_ROWS + 1, 2047);
            4: rc = $urandom_range(17, MAX_ROWS);
            5: rc = 1;
            default: rc = $urandom_range(1, 64);
         endcase
         run_phase(phase, rc);
         phase++;
      end

      req_valid <= 1'b0;
      while (pending_rslt.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      $display("Covered %0d loads, %0d lookups (%0d hits, %0d misses, %0d rows out of range)",
               n_loads, n_found + n_missing + n_range, n_found, n_missing, n_range);
      $display("over %0d row_count writes and %0d phases; %0d dropped transfers, %0d errors",
               n_settings, phase, n_ignored, mismatches);
      if (mismatches == 0)
         $display("csr_element_lookup_core: match");
      else
         $display("csr_element_lookup_core: mismatch");
      $finish;
   end

endmodule

// File: sim.f
src/csrel_pkg.sv
src/csrel_ram.sv
src/csrel_engine.sv
src/csr_element_lookup_core.sv
tb/tb_csr_element_lookup_core.sv
